>>> src/abt_pkg.sv
package abt_pkg;

    localparam int LINE_BITS = 24;
    localparam int COLUMN_BITS = 16;
    localparam int LENGTH_BITS = 16;
    localparam int MAX_HEX_DIGITS = 16;
    localparam int DIGIT_BITS = 5;

    typedef enum logic [3:0] {
        ST_BOM, ST_BOM_FF, ST_BOM_FE, ST_BEGIN, ST_COMMENT, ST_DIR_START,
        ST_LABEL_START, ST_WORD, ST_DOT, ST_SIGN_ZERO, ST_HEX_X, ST_HEX_FIRST,
        ST_HEX, ST_STR_BODY, ST_STR_ESC, ST_DRAIN
    } t_state;

    typedef enum logic [2:0] {
        K_NEWLINE = 3'd0, K_DIRECTIVE = 3'd1, K_UHEX = 3'd2, K_HEX = 3'd3,
        K_STRING = 3'd4, K_LABEL = 3'd5, K_LABEL_O = 3'd6, K_KEYWORD = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        EV_TOKEN = 2'd0, EV_DONE = 2'd1, EV_ERROR = 2'd2
    } t_event;

    typedef enum logic [1:0] {
        SIGN_NONE = 2'd0, SIGN_PLUS = 2'd1, SIGN_MINUS = 2'd2
    } t_sign;

    typedef struct packed {
        t_event                  ev;
        t_kind                   kind;
        logic [LINE_BITS-1:0]    line;
        logic [COLUMN_BITS-1:0]  column;
        logic [LENGTH_BITS-1:0]  length;
        logic                    last;
    } t_result;

    function automatic logic is_alpha_us(input logic [7:0] ch);
        return (ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a) || ch == 8'h5f;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= 8'h30 && ch <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == 8'h20 || ch == 8'h09 || ch == 8'h0d || ch == 8'h0b || ch == 8'h0c;
    endfunction

    function automatic logic is_hex(input logic [7:0] ch);
        return is_digit(ch) || (ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [7:0] v;
        v = 8'h00;
        if (is_digit(ch)) v = ch - 8'h30;
        else if (ch >= 8'h61 && ch <= 8'h66) v = ch - 8'h57;
        else if (ch >= 8'h41 && ch <= 8'h46) v = ch - 8'h37;
        return v[3:0];
    endfunction

endpackage

>>> src/assembly_byte_tokenizer_core.sv
// Results of a byte are registered and presented in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the output side keeps up. A byte that
// yields two results fills the two-entry result queue and holds off the next byte
// until one is taken; a stalled output with a result still waiting also holds it off.
// Reset (i_rst_n low, synchronous): the parser returns to the byte order mark
// check with line and column at one, and the result queue is emptied.
module assembly_byte_tokenizer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_source_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_event_kind,
    output logic [2:0]  o_token_kind,
    output logic [23:0] o_at_line,
    output logic [15:0] o_at_column,
    output logic [15:0] o_token_length,
    output logic        o_last_result
);

    localparam int LB = abt_pkg::LINE_BITS;
    localparam int CB = abt_pkg::COLUMN_BITS;
    localparam int NB = abt_pkg::LENGTH_BITS;
    localparam int DB = abt_pkg::DIGIT_BITS;

    // Parser state registers.
    abt_pkg::t_state        r_state;
    logic [LB-1:0]          r_line;
    logic [CB-1:0]          r_col;
    abt_pkg::t_kind         r_okind;
    logic [LB-1:0]          r_oline;
    logic [CB-1:0]          r_ocol;
    logic [NB-1:0]          r_olen;
    logic [DB-1:0]          r_digits;
    abt_pkg::t_sign         r_sign;
    logic [3:0]             r_mag;
    logic                   r_tail;
    logic                   r_nlp;
    logic                   r_seen;
    logic                   r_lastnl;

    abt_pkg::t_state        n_state;
    logic [LB-1:0]          n_line;
    logic [CB-1:0]          n_col;
    abt_pkg::t_kind         n_okind;
    logic [LB-1:0]          n_oline;
    logic [CB-1:0]          n_ocol;
    logic [NB-1:0]          n_olen;
    logic [DB-1:0]          n_digits;
    abt_pkg::t_sign         n_sign;
    logic [3:0]             n_mag;
    logic                   n_tail;
    logic                   n_nlp;
    logic                   n_seen;
    logic                   n_lastnl;

    // Results produced by the current byte (at most two).
    abt_pkg::t_result       res0, res1;
    logic [1:0]             res_n;

    // Output queue: two entries; a byte is accepted only when both can fit.
    abt_pkg::t_result       r_q [2];
    logic [1:0]             r_cnt;
    abt_pkg::t_result       n_q [2];
    logic [1:0]             n_cnt;

    logic acc_in, acc_out;
    assign o_stall = (r_cnt != 2'd0) && !(r_cnt == 2'd1 && !i_stall);
    assign acc_in  = i_valid && !o_stall;
    assign acc_out = o_valid && !i_stall;

    function automatic logic [NB-1:0] sat_len(input logic [NB-1:0] v, input logic [2:0] n);
        logic [NB:0] s;
        s = {1'b0, v} + {{(NB-2){1'b0}}, n};
        return s[NB] ? {NB{1'b1}} : s[NB-1:0];
    endfunction

    // Combinational single-pass evaluation of one byte, mirroring the
    // re-dispatch structure with at most two passes, the second one through ST_BEGIN.
    always_comb begin
        logic [7:0] ch;
        logic       fin, eof_ok, take, fail, word_end, cont_begin;
        logic       nl_lone, is_al, is_an;
        abt_pkg::t_state st;
        abt_pkg::t_result r;
        ch = i_source_byte;
        fin = i_final_byte;
        eof_ok = 1'b1;
        take = 1'b0;
        fail = 1'b0;
        word_end = 1'b0;
        cont_begin = 1'b0;
        nl_lone = 1'b0;
        is_al = abt_pkg::is_alpha_us(ch);
        is_an = is_al || abt_pkg::is_digit(ch);
        res0 = '0;
        res1 = '0;
        res_n = 2'd0;
        r = '0;
        n_state = r_state;
        n_line = r_line;
        n_col = r_col;
        n_okind = r_okind;
        n_oline = r_oline;
        n_ocol = r_ocol;
        n_olen = r_olen;
        n_digits = r_digits;
        n_sign = r_sign;
        n_mag = r_mag;
        n_tail = r_tail;
        n_nlp = r_nlp;
        n_seen = r_seen;
        n_lastnl = r_lastnl;
        st = r_state;

        // First pass: states take the byte, flag an error or fall to ST_BEGIN; ST_DRAIN ignores it.
        unique case (st)
            abt_pkg::ST_DRAIN: begin
            end
            abt_pkg::ST_BOM: begin
                if (ch == 8'hff) begin
                    n_state = abt_pkg::ST_BOM_FF; eof_ok = 1'b0; take = 1'b1;
                end else if (ch == 8'hfe) begin
                    n_state = abt_pkg::ST_BOM_FE; eof_ok = 1'b0; take = 1'b1;
                end else begin
                    cont_begin = 1'b1;
                end
            end
            abt_pkg::ST_BOM_FF, abt_pkg::ST_BOM_FE: begin
                if (ch == ((st == abt_pkg::ST_BOM_FF) ? 8'hfe : 8'hff)) fail = 1'b1;
                else begin
                    n_state = abt_pkg::ST_BEGIN; take = 1'b1;
                end
            end
            abt_pkg::ST_BEGIN: cont_begin = 1'b1;
            abt_pkg::ST_COMMENT: begin
                if (ch == 8'h0a) cont_begin = 1'b1;
                else take = 1'b1;
            end
            abt_pkg::ST_DIR_START, abt_pkg::ST_LABEL_START: begin
                if (!is_al) fail = 1'b1;
                else begin
                    n_okind = (st == abt_pkg::ST_DIR_START) ? abt_pkg::K_DIRECTIVE
                                                            : abt_pkg::K_LABEL;
                    n_oline = r_line; n_ocol = r_col; n_olen = NB'(2); n_seen = 1'b1;
                    n_state = abt_pkg::ST_WORD; take = 1'b1;
                end
            end
            abt_pkg::ST_WORD: begin
                if (is_an) begin
                    n_olen = sat_len(r_olen, 3'd1); take = 1'b1;
                end else if (ch == 8'h2e) begin
                    n_state = abt_pkg::ST_DOT; eof_ok = 1'b0; take = 1'b1;
                end else if ((ch == 8'h2b || ch == 8'h2d) && r_okind == abt_pkg::K_LABEL) begin
                    n_sign = (ch == 8'h2b) ? abt_pkg::SIGN_PLUS : abt_pkg::SIGN_MINUS;
                    n_state = abt_pkg::ST_SIGN_ZERO; eof_ok = 1'b0; take = 1'b1;
                end else word_end = 1'b1;
            end
            abt_pkg::ST_DOT: begin
                if (!is_al) fail = 1'b1;
                else begin
                    n_olen = sat_len(r_olen, 3'd2); n_state = abt_pkg::ST_WORD; take = 1'b1;
                end
            end
            abt_pkg::ST_SIGN_ZERO: begin
                if (ch != 8'h30) fail = 1'b1;
                else begin
                    n_state = abt_pkg::ST_HEX_X; eof_ok = 1'b0; take = 1'b1;
                end
            end
            abt_pkg::ST_HEX_X: begin
                if (ch != 8'h78) fail = 1'b1;
                else begin
                    n_state = abt_pkg::ST_HEX_FIRST; eof_ok = 1'b0; take = 1'b1;
                end
            end
            abt_pkg::ST_HEX_FIRST: begin
                if (!abt_pkg::is_hex(ch)) fail = 1'b1;
                else begin
                    if (r_okind == abt_pkg::K_LABEL) begin
                        n_okind = abt_pkg::K_LABEL_O;
                        n_olen = sat_len(r_olen, 3'd4);
                    end else begin
                        n_okind = (r_sign == abt_pkg::SIGN_NONE) ? abt_pkg::K_UHEX
                                                                 : abt_pkg::K_HEX;
                        n_olen = (r_sign == abt_pkg::SIGN_NONE) ? NB'(3) : NB'(4);
                        n_oline = r_line; n_ocol = r_col; n_seen = 1'b1;
                    end
                    n_digits = DB'(1);
                    n_mag = abt_pkg::hex_value(ch);
                    n_tail = 1'b0;
                    n_state = abt_pkg::ST_HEX; take = 1'b1;
                end
            end
            abt_pkg::ST_HEX: begin
                if (abt_pkg::is_hex(ch)) begin
                    if (r_digits >= DB'(abt_pkg::MAX_HEX_DIGITS)) fail = 1'b1;
                    else if (r_digits == DB'(15) && r_sign == abt_pkg::SIGN_PLUS
                             && r_mag >= 4'd8) fail = 1'b1;
                    else if (r_digits == DB'(15) && r_sign == abt_pkg::SIGN_MINUS
                             && (r_mag > 4'd8 || (r_mag == 4'd8 &&
                                 (r_tail || abt_pkg::hex_value(ch) != 4'd0)))) fail = 1'b1;
                    else begin
                        n_digits = r_digits + DB'(1);
                        if (abt_pkg::hex_value(ch) != 4'd0) n_tail = 1'b1;
                        n_olen = sat_len(r_olen, 3'd1); take = 1'b1;
                    end
                end else word_end = 1'b1;
            end
            abt_pkg::ST_STR_BODY, abt_pkg::ST_STR_ESC: begin
                n_olen = sat_len(r_olen, 3'd1);
                if (ch == 8'h22) begin
                    n_oline = r_line; n_ocol = r_col; n_seen = 1'b1;
                    res0 = '{abt_pkg::EV_TOKEN, r_okind, r_line, r_col, n_olen, 1'b0};
                    res_n = 2'd1;
                    n_state = abt_pkg::ST_BEGIN;
                end else begin
                    n_state = (st == abt_pkg::ST_STR_BODY && ch == 8'h5c)
                              ? abt_pkg::ST_STR_ESC : abt_pkg::ST_STR_BODY;
                    eof_ok = 1'b0;
                end
                take = 1'b1;
            end
            default: cont_begin = 1'b1;
        endcase

        if (word_end) begin
            if (abt_pkg::is_blank(ch)) begin
                res0 = '{abt_pkg::EV_TOKEN, r_okind, r_oline, r_ocol, n_olen, 1'b0};
                res_n = 2'd1; n_state = abt_pkg::ST_BEGIN; take = 1'b1;
            end else if (ch == 8'h0a) begin
                res0 = '{abt_pkg::EV_TOKEN, r_okind, r_oline, r_ocol, n_olen, 1'b0};
                res_n = 2'd1; cont_begin = 1'b1;
            end else fail = 1'b1;
        end

        // ST_BEGIN dispatch (second pass where the first one fell through).
        if (cont_begin) begin
            n_state = abt_pkg::ST_BEGIN;
            take = 1'b1;
            if (ch == 8'h0a) begin
                if (n_seen && !r_lastnl) begin
                    n_okind = abt_pkg::K_NEWLINE; n_oline = r_line; n_ocol = r_col;
                    n_olen = NB'(1); n_nlp = 1'b1; n_lastnl = 1'b1;
                end
            end else if (abt_pkg::is_blank(ch)) begin
            end else if (ch == 8'h23) begin
                n_state = abt_pkg::ST_COMMENT;
            end else if (ch == 8'h2e || ch == 8'h2b || ch == 8'h2d || ch == 8'h30
                         || ch == 8'h22 || ch == 8'h3a || is_al) begin
                nl_lone = r_nlp;
                n_nlp = 1'b0; n_lastnl = 1'b0; n_olen = '0;
                if (ch == 8'h2e) begin
                    n_okind = abt_pkg::K_DIRECTIVE; n_state = abt_pkg::ST_DIR_START;
                    eof_ok = 1'b0;
                end else if (ch == 8'h22) begin
                    n_okind = abt_pkg::K_STRING; n_olen = NB'(1);
                    n_state = abt_pkg::ST_STR_BODY; eof_ok = 1'b0;
                end else if (ch == 8'h3a) begin
                    n_okind = abt_pkg::K_LABEL; n_state = abt_pkg::ST_LABEL_START;
                    eof_ok = 1'b0;
                end else if (is_al) begin
                    n_okind = abt_pkg::K_KEYWORD; n_oline = r_line; n_ocol = r_col;
                    n_olen = NB'(1); n_seen = 1'b1; n_state = abt_pkg::ST_WORD;
                end else begin
                    n_okind = abt_pkg::K_UHEX;
                    n_sign = (ch == 8'h30) ? abt_pkg::SIGN_NONE :
                             (ch == 8'h2b) ? abt_pkg::SIGN_PLUS : abt_pkg::SIGN_MINUS;
                    n_state = (ch == 8'h30) ? abt_pkg::ST_HEX_X : abt_pkg::ST_SIGN_ZERO;
                    eof_ok = 1'b0;
                end
            end else begin
                take = 1'b0; fail = 1'b1;
            end
        end

        // The held newline is the only result that can precede a token start.
        if (nl_lone) begin
            res0 = '{abt_pkg::EV_TOKEN, abt_pkg::K_NEWLINE, r_oline, r_ocol, NB'(1), 1'b0};
            res_n = 2'd1;
        end

        if (take) begin
            if (ch == 8'h0a) begin
                n_line = (r_line == {LB{1'b1}}) ? r_line : r_line + LB'(1);
                n_col = CB'(1);
            end else begin
                n_col = (r_col == {CB{1'b1}}) ? r_col : r_col + CB'(1);
            end
            if (fin) begin
                if (!eof_ok) begin
                    r = '{abt_pkg::EV_ERROR, abt_pkg::K_NEWLINE, n_line, n_col, '0, 1'b1};
                end else begin
                    r = '{abt_pkg::EV_DONE, abt_pkg::K_NEWLINE, n_line, n_col, '0, 1'b1};
                    if (n_state == abt_pkg::ST_WORD || n_state == abt_pkg::ST_HEX) begin
                        if (res_n != 2'd0) begin
                            r = '{abt_pkg::EV_TOKEN, n_okind, n_oline, n_ocol, n_olen, 1'b1};
                        end else begin
                            res0 = '{abt_pkg::EV_TOKEN, n_okind, n_oline, n_ocol, n_olen,
                                     1'b0};
                            res_n = 2'd1;
                        end
                    end
                end
            end
        end
        if (fail) begin
            r = '{abt_pkg::EV_ERROR, abt_pkg::K_NEWLINE, r_line, r_col, '0, 1'b1};
            n_state = abt_pkg::ST_DRAIN;
        end
        if (fail || (take && fin)) begin
            if (res_n == 2'd0) begin
                res0 = r; res_n = 2'd1;
            end else begin
                res1 = r; res_n = 2'd2;
            end
        end
        if (fin && (take || fail || st == abt_pkg::ST_DRAIN)) begin
            n_state = abt_pkg::ST_BOM;
            n_line = LB'(1); n_col = CB'(1);
            n_okind = abt_pkg::K_NEWLINE; n_oline = '0; n_ocol = '0; n_olen = '0;
            n_digits = '0; n_sign = abt_pkg::SIGN_NONE; n_mag = '0; n_tail = 1'b0;
            n_nlp = 1'b0; n_seen = 1'b0; n_lastnl = 1'b0;
        end
    end

    // Queue update: pop head on output transaction, then append new results.
    always_comb begin
        abt_pkg::t_result q0, q1;
        logic [1:0] c;
        q0 = r_q[0];
        q1 = r_q[1];
        c = r_cnt;
        if (acc_out) begin
            q0 = q1; c = c - 2'd1;
        end
        if (acc_in && res_n != 2'd0) begin
            if (c == 2'd0) begin
                q0 = res0; q1 = res1;
            end else begin
                q1 = res0;
            end
            c = c + res_n;
        end
        n_q[0] = q0;
        n_q[1] = q1;
        n_cnt = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= abt_pkg::ST_BOM;
            r_line <= LB'(1);
            r_col <= CB'(1);
            r_okind <= abt_pkg::K_NEWLINE;
            r_oline <= '0;
            r_ocol <= '0;
            r_olen <= '0;
            r_digits <= '0;
            r_sign <= abt_pkg::SIGN_NONE;
            r_mag <= '0;
            r_tail <= 1'b0;
            r_nlp <= 1'b0;
            r_seen <= 1'b0;
            r_lastnl <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc_in) begin
                r_state <= n_state;
                r_line <= n_line;
                r_col <= n_col;
                r_okind <= n_okind;
                r_oline <= n_oline;
                r_ocol <= n_ocol;
                r_olen <= n_olen;
                r_digits <= n_digits;
                r_sign <= n_sign;
                r_mag <= n_mag;
                r_tail <= n_tail;
                r_nlp <= n_nlp;
                r_seen <= n_seen;
                r_lastnl <= n_lastnl;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_valid        = r_cnt != 2'd0;
    assign o_event_kind   = r_q[0].ev;
    assign o_token_kind   = r_q[0].kind;
    assign o_at_line      = r_q[0].line;
    assign o_at_column    = r_q[0].column;
    assign o_token_length = r_q[0].length;
    assign o_last_result  = r_q[0].last;

    // The queue never holds more than two results.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("result queue overflow");

    // Line and column never fall below one.
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_col != '0) else $error("position counter reached zero");

    // An accepted byte that ends in an error leaves the parser draining or reset.
    a_err_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && res_n != 2'd0 && ((res_n == 2'd1 && res0.ev == abt_pkg::EV_ERROR) ||
         (res_n == 2'd2 && res1.ev == abt_pkg::EV_ERROR)))
        |=> (r_state == abt_pkg::ST_DRAIN || r_state == abt_pkg::ST_BOM))
        else $error("error did not stop parsing");

endmodule

>>> test/abt_checker.sv
module abt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_source_byte,
    input  logic        i_final_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_event_kind,
    input  logic [2:0]  i_token_kind,
    input  logic [23:0] i_at_line,
    input  logic [15:0] i_at_column,
    input  logic [15:0] i_token_length,
    input  logic        i_last_result,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LB = abt_pkg::LINE_BITS;
    localparam int CB = abt_pkg::COLUMN_BITS;
    localparam int NB = abt_pkg::LENGTH_BITS;

    abt_pkg::t_state   p_state;
    logic [LB-1:0]     line_q;
    logic [CB-1:0]     col_q;
    abt_pkg::t_kind    tok_kind;
    logic [LB-1:0]     tok_line;
    logic [CB-1:0]     tok_col;
    logic [NB-1:0]     tok_len;
    int                digits;
    abt_pkg::t_sign    sign_q;
    logic [3:0]        mag_high;
    logic              tail_nz, nl_held, seen_tok, was_nl;
    abt_pkg::t_result  token_queue[$];
    int                new_count;

    assign o_pending = token_queue.size();

    function automatic logic alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0b || c == 8'h0c;
    endfunction

    function automatic int hexval(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    task automatic push(input abt_pkg::t_event ev, input abt_pkg::t_kind k,
                        input logic [LB-1:0] ln, input logic [CB-1:0] cl,
                        input logic [NB-1:0] len, input logic last);
        abt_pkg::t_result r;
        if (new_count >= 2) return;
        r.ev = ev; r.kind = k; r.line = ln; r.column = cl; r.length = len; r.last = last;
        token_queue.push_back(r);
        new_count++;
    endtask

    task automatic clear_state();
        p_state = abt_pkg::ST_BOM; line_q = LB'(1); col_q = CB'(1);
        tok_kind = abt_pkg::K_NEWLINE; tok_line = '0; tok_col = '0; tok_len = '0;
        digits = 0; sign_q = abt_pkg::SIGN_NONE; mag_high = '0;
        tail_nz = 1'b0; nl_held = 1'b0; seen_tok = 1'b0; was_nl = 1'b0;
    endtask

    function automatic logic [NB-1:0] len_add(input int n);
        longint s;
        s = longint'(tok_len) + n;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    task automatic open_token(input abt_pkg::t_kind k);
        if (nl_held) push(abt_pkg::EV_TOKEN, abt_pkg::K_NEWLINE, tok_line, tok_col,
                          NB'(1), 1'b0);
        nl_held = 1'b0; was_nl = 1'b0; tok_kind = k; tok_len = '0;
    endtask

    task automatic mark(input abt_pkg::t_kind k, input int len);
        tok_kind = k; tok_line = line_q; tok_col = col_q; tok_len = NB'(len);
        seen_tok = 1'b1;
    endtask

    // Walks one byte through the tokenizer state and queues the results it causes.
    task automatic tokenize_byte(input logic [7:0] c, input logic fin);
        logic eof_ok, done, failed, word_end;
        int hv;
        eof_ok = 1; done = 0; failed = 0;
        new_count = 0;
        if (p_state == abt_pkg::ST_DRAIN) begin
            if (fin) clear_state();
            return;
        end
        while (!done && !failed) begin
            word_end = 0;
            done = 1;
            case (p_state)
                abt_pkg::ST_BOM: begin
                    if (c == 8'hFF) begin
                        p_state = abt_pkg::ST_BOM_FF; eof_ok = 0;
                    end else if (c == 8'hFE) begin
                        p_state = abt_pkg::ST_BOM_FE; eof_ok = 0;
                    end else begin
                        p_state = abt_pkg::ST_BEGIN; done = 0;
                    end
                end
                abt_pkg::ST_BOM_FF, abt_pkg::ST_BOM_FE: begin
                    if (c == ((p_state == abt_pkg::ST_BOM_FF) ? 8'hFE : 8'hFF)) failed = 1;
                    else p_state = abt_pkg::ST_BEGIN;
                end
                abt_pkg::ST_BEGIN: begin
                    if (c == "\n") begin
                        if (seen_tok && !was_nl) begin
                            tok_kind = abt_pkg::K_NEWLINE; tok_line = line_q; tok_col = col_q;
                            tok_len = NB'(1); nl_held = 1; was_nl = 1;
                        end
                    end else if (blank(c)) begin
                    end else if (c == "#") begin
                        p_state = abt_pkg::ST_COMMENT;
                    end else if (c == ".") begin
                        open_token(abt_pkg::K_DIRECTIVE);
                        p_state = abt_pkg::ST_DIR_START; eof_ok = 0;
                    end else if (c == "+" || c == "-" || c == "0") begin
                        open_token(abt_pkg::K_UHEX);
                        sign_q = (c == "0") ? abt_pkg::SIGN_NONE :
                                 ((c == "+") ? abt_pkg::SIGN_PLUS : abt_pkg::SIGN_MINUS);
                        p_state = (c == "0") ? abt_pkg::ST_HEX_X : abt_pkg::ST_SIGN_ZERO;
                        eof_ok = 0;
                    end else if (c == "\"") begin
                        open_token(abt_pkg::K_STRING); tok_len = NB'(1);
                        p_state = abt_pkg::ST_STR_BODY; eof_ok = 0;
                    end else if (c == ":") begin
                        open_token(abt_pkg::K_LABEL);
                        p_state = abt_pkg::ST_LABEL_START; eof_ok = 0;
                    end else if (alpha(c)) begin
                        open_token(abt_pkg::K_KEYWORD); mark(abt_pkg::K_KEYWORD, 1);
                        p_state = abt_pkg::ST_WORD;
                    end else begin
                        failed = 1;
                    end
                end
                abt_pkg::ST_COMMENT: begin
                    if (c == "\n") begin
                        p_state = abt_pkg::ST_BEGIN; done = 0;
                    end
                end
                abt_pkg::ST_DIR_START, abt_pkg::ST_LABEL_START: begin
                    if (!alpha(c)) failed = 1;
                    else begin
                        mark((p_state == abt_pkg::ST_DIR_START) ? abt_pkg::K_DIRECTIVE
                                                                : abt_pkg::K_LABEL, 2);
                        p_state = abt_pkg::ST_WORD;
                    end
                end
                abt_pkg::ST_WORD: begin
                    if (alpha(c) || (c >= "0" && c <= "9")) tok_len = len_add(1);
                    else if (c == ".") begin
                        p_state = abt_pkg::ST_DOT; eof_ok = 0;
                    end else if ((c == "+" || c == "-") && tok_kind == abt_pkg::K_LABEL) begin
                        sign_q = (c == "+") ? abt_pkg::SIGN_PLUS : abt_pkg::SIGN_MINUS;
                        p_state = abt_pkg::ST_SIGN_ZERO; eof_ok = 0;
                    end else word_end = 1;
                end
                abt_pkg::ST_DOT: begin
                    if (!alpha(c)) failed = 1;
                    else begin
                        tok_len = len_add(2); p_state = abt_pkg::ST_WORD;
                    end
                end
                abt_pkg::ST_SIGN_ZERO: begin
                    if (c != "0") failed = 1;
                    else begin
                        p_state = abt_pkg::ST_HEX_X; eof_ok = 0;
                    end
                end
                abt_pkg::ST_HEX_X: begin
                    if (c != "x") failed = 1;
                    else begin
                        p_state = abt_pkg::ST_HEX_FIRST; eof_ok = 0;
                    end
                end
                abt_pkg::ST_HEX_FIRST: begin
                    hv = hexval(c);
                    if (hv < 0) failed = 1;
                    else begin
                        if (tok_kind == abt_pkg::K_LABEL) begin
                            tok_kind = abt_pkg::K_LABEL_O; tok_len = len_add(4);
                        end else if (sign_q == abt_pkg::SIGN_NONE) mark(abt_pkg::K_UHEX, 3);
                        else mark(abt_pkg::K_HEX, 4);
                        digits = 1; mag_high = 4'(hv); tail_nz = 0;
                        p_state = abt_pkg::ST_HEX;
                    end
                end
                abt_pkg::ST_HEX: begin
                    hv = hexval(c);
                    if (hv >= 0) begin
                        if (digits >= abt_pkg::MAX_HEX_DIGITS) failed = 1;
                        else begin
                            digits++;
                            if (hv != 0) tail_nz = 1;
                            if (digits == 16) begin
                                if (sign_q == abt_pkg::SIGN_PLUS && mag_high >= 4'd8)
                                    failed = 1;
                                if (sign_q == abt_pkg::SIGN_MINUS && (mag_high > 4'd8 ||
                                    (mag_high == 4'd8 && tail_nz))) failed = 1;
                            end
                            if (!failed) tok_len = len_add(1);
                        end
                    end else word_end = 1;
                end
                abt_pkg::ST_STR_BODY, abt_pkg::ST_STR_ESC: begin
                    tok_len = len_add(1);
                    if (c == "\"") begin
                        tok_line = line_q; tok_col = col_q; seen_tok = 1;
                        push(abt_pkg::EV_TOKEN, tok_kind, tok_line, tok_col, tok_len, 1'b0);
                        p_state = abt_pkg::ST_BEGIN;
                    end else begin
                        p_state = (p_state == abt_pkg::ST_STR_BODY && c == "\\")
                                  ? abt_pkg::ST_STR_ESC : abt_pkg::ST_STR_BODY;
                        eof_ok = 0;
                    end
                end
                default: begin
                    p_state = abt_pkg::ST_BEGIN; done = 0;
                end
            endcase
            if (word_end) begin
                if (blank(c)) begin
                    push(abt_pkg::EV_TOKEN, tok_kind, tok_line, tok_col, tok_len, 1'b0);
                    p_state = abt_pkg::ST_BEGIN;
                end else if (c == "\n") begin
                    push(abt_pkg::EV_TOKEN, tok_kind, tok_line, tok_col, tok_len, 1'b0);
                    p_state = abt_pkg::ST_BEGIN; done = 0;
                end else failed = 1;
            end
        end
        if (failed) begin
            push(abt_pkg::EV_ERROR, abt_pkg::K_NEWLINE, line_q, col_q, '0, 1'b1);
            if (fin) clear_state();
            else p_state = abt_pkg::ST_DRAIN;
            return;
        end
        if (c == "\n") begin
            line_q = (line_q == '1) ? line_q : line_q + LB'(1);
            col_q = CB'(1);
        end else col_q = (col_q == '1) ? col_q : col_q + CB'(1);
        if (fin) begin
            if (!eof_ok) push(abt_pkg::EV_ERROR, abt_pkg::K_NEWLINE, line_q, col_q, '0, 1'b1);
            else begin
                // A word or number still open at the end is closed first; if a held
                // newline already took a slot, the token itself carries the end flag.
                if (p_state == abt_pkg::ST_WORD || p_state == abt_pkg::ST_HEX) begin
                    if (new_count >= 1) begin
                        push(abt_pkg::EV_TOKEN, tok_kind, tok_line, tok_col, tok_len, 1'b1);
                        clear_state();
                        return;
                    end
                    push(abt_pkg::EV_TOKEN, tok_kind, tok_line, tok_col, tok_len, 1'b0);
                end
                push(abt_pkg::EV_DONE, abt_pkg::K_NEWLINE, line_q, col_q, '0, 1'b1);
            end
            clear_state();
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        abt_pkg::t_result want;
        if (!i_rst_n) begin
            clear_state();
            token_queue.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (token_queue.size() == 0) begin
                    report_mismatch("unexpected result", i_event_kind, 0);
                end else begin
                    want = token_queue.pop_front();
                    if (i_event_kind != want.ev) report_mismatch("event", i_event_kind, want.ev);
                    if (i_token_kind != want.kind)
                        report_mismatch("token kind", i_token_kind, want.kind);
                    if (i_at_line != want.line) report_mismatch("line", i_at_line, want.line);
                    if (i_at_column != want.column)
                        report_mismatch("column", i_at_column, want.column);
                    if (i_token_length != want.length)
                        report_mismatch("length", i_token_length, want.length);
                    if (i_last_result != want.last)
                        report_mismatch("last", i_last_result, want.last);
                end
            end
            if (i_valid && !i_stall_in) tokenize_byte(i_source_byte, i_final_byte);
        end
    end
endmodule

>>> test/tb_assembly_byte_tokenizer_core.sv
module tb_assembly_byte_tokenizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [7:0]  i_source_byte = 0;
    logic        i_final_byte = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_event_kind;
    logic [2:0]  o_token_kind;
    logic [23:0] o_at_line;
    logic [15:0] o_at_column;
    logic [15:0] o_token_length;
    logic        o_last_result;
    int          fail_count;
    int          pending;
    bit          quiet;     // While set, neither side idles.
    byte unsigned source_text[$];
    bit           final_mark[$];

    always #6 i_clk = ~i_clk;

    assembly_byte_tokenizer_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_source_byte(i_source_byte), .i_final_byte(i_final_byte),
        .o_valid(o_valid), .i_stall(i_stall), .o_event_kind(o_event_kind),
        .o_token_kind(o_token_kind), .o_at_line(o_at_line), .o_at_column(o_at_column),
        .o_token_length(o_token_length), .o_last_result(o_last_result)
    );

    abt_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_source_byte(i_source_byte), .i_final_byte(i_final_byte),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_event_kind(o_event_kind),
        .i_token_kind(o_token_kind), .i_at_line(o_at_line), .i_at_column(o_at_column),
        .i_token_length(o_token_length), .i_last_result(o_last_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls at random, with a six percent chance each time, unless quiet is set.
    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 6);
    end

    // Appends a program given as a string; the last character carries the final flag.
    task automatic add_program(input string s);
        for (int k = 0; k < s.len(); k++) begin
            source_text.push_back(s[k]);
            final_mark.push_back(k == s.len() - 1);
        end
    endtask

    function automatic string random_piece();
        string hexd;
        int n;
        hexd = "0123456789abcdefABCDEF";
        case ($urandom_range(13))
            0: return "mov ";
            1: return ".data ";
            2: return "\n";
            3: return "\n\n";
            4: return "# note here\n";
            5: return ":loop ";
            6: return ":tbl+0x1F ";
            7: return "\"a\\\"b\" ";
            8: return "\"x\\y\" ";
            9: return "r1.q ";
            10: begin
                string s;
                n = $urandom_range(1, 17);
                s = ($urandom_range(2) == 0) ? "+0x" : (($urandom_range(1) == 0) ? "-0x"
                                                                                 : "0x");
                for (int k = 0; k < n; k++) s = {s, string'(hexd[$urandom_range(21)])};
                return {s, " "};
            end
            11: return "\t";
            12: begin
                string s;
                s = " ";
                s[0] = byte'($urandom_range(255));
                return s;
            end
            default: return "_x9 ";
        endcase
    endfunction

    initial begin
        string prog;
        int idx;
        quiet = 0;
        // Directed programs: every token kind, held and trailing newlines, byte order
        // marks, range limits of signed numbers and the crowded end with two results.
        add_program("mov .d\n\n0xF 0x0 \"s\\\"\" :l :l-0x8 x\n");
        add_program(string'({8'hFF, 8'hFE}));
        add_program(string'({8'hFE, 8'h41, "a"}));
        add_program("+0x7fffffffffffffff -0x8000000000000000 +0x8000000000000000");
        add_program("-0x8000000000000001");
        add_program("0x00000000000000000");
        add_program("a\nb");
        add_program("!");
        add_program("\"open");
        add_program(string'({"0x1", 8'h80}));
        for (int k = 0; k < 850; k++) begin
            prog = "";
            idx = $urandom_range(1, 6);
            for (int j = 0; j < idx; j++) prog = {prog, random_piece()};
            if ($urandom_range(9) == 0) prog = {string'(8'hFF), prog};
            add_program(prog);
            if (source_text.size() >= 850) break;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        idx = 0;
        while (idx < source_text.size()) begin
            // A quiet stretch somewhere in the middle of the run.
            quiet = (idx > 300 && idx < 500);
            if (!quiet && $urandom_range(99) < 6) begin
                i_valid <= 0;
                @(posedge i_clk);
            end else begin
                i_valid <= 1;
                i_source_byte <= source_text[idx];
                i_final_byte <= final_mark[idx];
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                idx++;
            end
        end
        i_valid <= 0;
        quiet = 1;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
